// ===== sv/drqw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drqw_pkg
// Shared types, constants and helpers of the depth quantized row warp.
// ----------------------------------------------------------------------------
package drqw_pkg;

    // number of depth levels, and so of window cells
    localparam int NUM_LEVELS = 8;

    localparam int PIX_W   = 8;
    localparam int DEPTH_W = 8;
    localparam int LVL_W   = $clog2(NUM_LEVELS + 1);

    // span = ceiling - floor + 1 reaches 256
    localparam int SPAN_W  = DEPTH_W + 1;
    localparam int STEP_W  = DEPTH_W + 1;
    // floor plus level times step stays below 512
    localparam int THR_W   = DEPTH_W + 2;

    // span / NUM_LEVELS through a reciprocal, exact for all spans up to 2**SPAN_W
    localparam int DIV_SH    = 18;
    localparam int DIV_RECIP = ((1 << DIV_SH) + NUM_LEVELS - 1) / NUM_LEVELS;
    localparam int DIV_RW    = DIV_SH + 1;
    localparam int PROD_W    = SPAN_W + DIV_RW;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_FLOOR   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_CEILING = CFG_IDX_W'(1);

    localparam logic [DEPTH_W-1:0] FLOOR_RESET   = DEPTH_W'(0);
    localparam logic [DEPTH_W-1:0] CEILING_RESET = DEPTH_W'(255);

    // step that follows from the reset floor and ceiling
    localparam int RESET_STEP = (int'(CEILING_RESET) - int'(FLOOR_RESET) + 1) / NUM_LEVELS;

    typedef struct packed {
        logic              valid;
        logic [LVL_W-1:0]  level;
        logic [PIX_W-1:0]  red;
        logic [PIX_W-1:0]  green;
        logic [PIX_W-1:0]  blue;
    } slot_t;

    typedef struct packed {
        logic [LVL_W-1:0]  level;
        logic [PIX_W-1:0]  red;
        logic [PIX_W-1:0]  green;
        logic [PIX_W-1:0]  blue;
    } pix_t;

    typedef struct packed {
        logic shift;   // advance the window by one column
        logic clear;   // row end: empty every cell
    } cell_ctrl_t;

    localparam slot_t SLOT_EMPTY = '0;

    // threshold of lane k right after reset
    function automatic logic [THR_W-1:0] thr_reset(input int k);
        return THR_W'(int'(FLOOR_RESET) + (k + 1) * RESET_STEP);
    endfunction

endpackage

// ===== sv/drqw_quant.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drqw_quant
// Level thresholds kept from the floor and ceiling, and the level of a depth.
// ----------------------------------------------------------------------------
module drqw_quant import drqw_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [DEPTH_W-1:0] depth_floor,
    input  logic [DEPTH_W-1:0] depth_ceiling,
    input  logic [DEPTH_W-1:0] depth_value,
    output logic [LVL_W-1:0]   level
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [SPAN_W-1:0] span;
    logic [PROD_W-1:0] prod;
    logic [THR_W-1:0]  thr_reg  [NUM_LEVELS];
    logic [THR_W-1:0]  thr_next [NUM_LEVELS];

    // step is zero when the ceiling is below the floor
    always_comb begin
        span = SPAN_W'(depth_ceiling) - SPAN_W'(depth_floor) + SPAN_W'(1);
        prod = PROD_W'(span) * PROD_W'(DIV_RW'(DIV_RECIP));
        if (depth_ceiling >= depth_floor) begin
            step_next = prod[DIV_SH +: STEP_W];
        end else begin
            step_next = '0;
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_LEVELS; k++) begin
            thr_next[k] = THR_W'(depth_floor) + THR_W'(32'(k + 1) * 32'(step_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_W'(RESET_STEP);
            for (int k = 0; k < NUM_LEVELS; k++) begin
                thr_reg[k] <= thr_reset(k);
            end
        end else begin
            step_reg <= step_next;
            for (int k = 0; k < NUM_LEVELS; k++) begin
                thr_reg[k] <= thr_next[k];
            end
        end
    end

    // first lane whose threshold covers the depth; clamp to the top level
    always_comb begin
        level = LVL_W'(NUM_LEVELS);
        for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
            if (THR_W'(depth_value) <= thr_reg[k]) begin
                level = LVL_W'(k + 1);
            end
        end
    end

endmodule

// ===== sv/drqw_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drqw_cell
// One column slot of the warp window; takes its neighbor's slot on a shift.
// ----------------------------------------------------------------------------
module drqw_cell import drqw_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  logic       hit,
    input  pix_t       pix,
    input  slot_t      upstream,
    output slot_t      entry
);

    slot_t entry_reg;
    slot_t entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.clear) begin
            entry_next.valid = 1'b0;
        end else if (ctrl.shift) begin
            entry_next = upstream;
            // strictly higher level wins; equal level keeps the occupant
            if (hit && (!upstream.valid || pix.level > upstream.level)) begin
                entry_next.valid = 1'b1;
                entry_next.level = pix.level;
                entry_next.red   = pix.red;
                entry_next.green = pix.green;
                entry_next.blue  = pix.blue;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else begin
            entry_reg.valid <= entry_next.valid;
        end
        entry_reg.level <= entry_next.level;
        entry_reg.red   <= entry_next.red;
        entry_reg.green <= entry_next.green;
        entry_reg.blue  <= entry_next.blue;
    end

    assign entry = entry_reg;

endmodule

// ===== sv/depth_quantized_row_warp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_quantized_row_warp
// Forward row warp with a per-row depth buffer held in a chain of cells.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  s_       | in        | s_valid / s_ready  | red, green, blue, depth, row end
//  m_       | out       | m_valid / m_ready  | red, green, blue, filled, row end
//  cfg_     | in        | cfg_valid/cfg_ready| register index, write data
//
//  One item per clock sustained while m_ready keeps the output draining. A
//  taken item passes the input register, a delay stage, the level stage and
//  the output register, the first of which loads at the accepting edge.
//  The window is a row of NUM_LEVELS cells that shift on an ordinary item and
//  clear on a row end. Reset empties every cell and restores floor 0 and ceiling 255.
//  A stall on m_ready freezes the whole pipe; s_ready drops in the same cycle.
//  Threshold registers follow a configuration write through the step register.
//
module depth_quantized_row_warp import drqw_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PIX_W-1:0]     s_red,
    input  logic [PIX_W-1:0]     s_green,
    input  logic [PIX_W-1:0]     s_blue,
    input  logic [DEPTH_W-1:0]   s_depth_value,
    input  logic                 s_row_end,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PIX_W-1:0]     m_out_red,
    output logic [PIX_W-1:0]     m_out_green,
    output logic [PIX_W-1:0]     m_out_blue,
    output logic                 m_filled,
    output logic                 m_out_row_end,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DEPTH_W-1:0]   cfg_data
);

    // configuration registers
    logic [DEPTH_W-1:0] floor_reg;
    logic [DEPTH_W-1:0] ceiling_reg;

    // pipe stages: s0 input register, s1 delay, s2 quantized item
    logic               s0_valid_reg, s1_valid_reg, s2_valid_reg;
    pix_t               s0_pix_reg,   s1_pix_reg,   s2_pix_reg;
    logic [DEPTH_W-1:0] s0_depth_reg, s1_depth_reg;
    logic               s0_last_reg,  s1_last_reg,  s2_last_reg;
    logic [LVL_W-1:0]   s1_level;

    // output register
    logic               m_valid_reg;
    logic [PIX_W-1:0]   m_red_reg, m_green_reg, m_blue_reg;
    logic               m_filled_reg;
    logic               m_last_reg;

    logic               advance;
    cell_ctrl_t         ctrl;
    slot_t              entry [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] hit;

    // advance the pipe whenever the output register is free or being drained
    assign advance   = !m_valid_reg || m_ready;
    assign s_ready   = advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg   <= FLOOR_RESET;
            ceiling_reg <= CEILING_RESET;
        end else if (cfg_valid) begin
            // drop writes to indexes beyond the register list
            if (cfg_index == REG_DEPTH_FLOOR) begin
                floor_reg <= cfg_data;
            end else if (cfg_index == REG_DEPTH_CEILING) begin
                ceiling_reg <= cfg_data;
            end
        end
    end

    drqw_quant u_quant (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .depth_floor   (floor_reg),
        .depth_ceiling (ceiling_reg),
        .depth_value   (s1_depth_reg),
        .level         (s1_level)
    );

    // valid bits of the pipe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (advance) begin
            s0_valid_reg <= s_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            m_valid_reg  <= s2_valid_reg;
        end
    end

    // payload of the pipe; the level joins the item on its way into s2
    always_ff @(posedge aclk) begin
        if (advance) begin
            s0_pix_reg.level <= '0;
            s0_pix_reg.red   <= s_red;
            s0_pix_reg.green <= s_green;
            s0_pix_reg.blue  <= s_blue;
            s0_depth_reg     <= s_depth_value;
            s0_last_reg      <= s_row_end;

            s1_pix_reg   <= s0_pix_reg;
            s1_depth_reg <= s0_depth_reg;
            s1_last_reg  <= s0_last_reg;

            s2_pix_reg  <= '{level: s1_level, red: s1_pix_reg.red,
                             green: s1_pix_reg.green, blue: s1_pix_reg.blue};
            s2_last_reg <= s1_last_reg;

            // emit the head column; holes read as black
            m_red_reg    <= entry[0].valid ? entry[0].red   : '0;
            m_green_reg  <= entry[0].valid ? entry[0].green : '0;
            m_blue_reg   <= entry[0].valid ? entry[0].blue  : '0;
            m_filled_reg <= entry[0].valid;
            m_last_reg   <= s2_last_reg;
        end
    end

    // shift on an ordinary pixel, clear on the row end; the row-end pixel's
    // own write lands past the row and is dropped
    always_comb begin
        ctrl.shift = advance && s2_valid_reg && !s2_last_reg;
        ctrl.clear = advance && s2_valid_reg &&  s2_last_reg;
    end

    // after the shift, cell k stands for column j + k + 1, the target of level k + 1
    always_comb begin
        for (int k = 0; k < NUM_LEVELS; k++) begin
            hit[k] = (s2_pix_reg.level == LVL_W'(k + 1));
        end
    end

    genvar gk;
    generate
        for (gk = 0; gk < NUM_LEVELS; gk++) begin : g_cell
            slot_t upstream;
            if (gk == NUM_LEVELS - 1) begin : g_tail
                assign upstream = SLOT_EMPTY;
            end else begin : g_body
                assign upstream = entry[gk + 1];
            end
            drqw_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (ctrl),
                .hit      (hit[gk]),
                .pix      (s2_pix_reg),
                .upstream (upstream),
                .entry    (entry[gk])
            );
        end
    endgenerate

    assign m_valid       = m_valid_reg;
    assign m_out_red     = m_red_reg;
    assign m_out_green   = m_green_reg;
    assign m_out_blue    = m_blue_reg;
    assign m_filled      = m_filled_reg;
    assign m_out_row_end = m_last_reg;

endmodule

// ===== sv/drqw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drqw_checker
// Port-level checks of the row warp, bound to the top level.
// ----------------------------------------------------------------------------
module drqw_checker import drqw_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_ready,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [PIX_W-1:0]     m_out_red,
    input  logic [PIX_W-1:0]     m_out_green,
    input  logic [PIX_W-1:0]     m_out_blue,
    input  logic                 m_filled,
    input  logic                 m_out_row_end
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_red) && $stable(m_out_green)
            && $stable(m_out_blue) && $stable(m_filled) && $stable(m_out_row_end))
        else $error("stalled result changed");

    // a hole carries black
    a_hole_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_filled |-> m_out_red == '0 && m_out_green == '0 && m_out_blue == '0)
        else $error("hole with nonzero color");

    // a stalled output stops intake in the same cycle
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

endmodule

bind depth_quantized_row_warp drqw_checker u_drqw_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the depth quantized row warp: drives pixel rows with
// random colors and depths, predicts every output column from its own copy of
// the warp window, and checks each column field by field under random stalls.
// ----------------------------------------------------------------------------
module tb;
    import drqw_pkg::*;

    // one output column as the block should emit it
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             filled;
        logic             row_end;
    } column_t;

    // flow-control regimes of the run
    typedef enum int {SENDER_SLOW, RECEIVER_SLOW, FULL_RATE} pace_t;

    localparam int QUIET_LIMIT = 4000;   // cycles with no handshake before giving up
    localparam int CHUNKS      = 8;
    localparam int CHUNK_ITEMS = 235;

    // ------------------------------------------------------------------------
    // Predictor and checker: holds its own window and depth range, turns each
    // accepted pixel into the column due next, and compares arriving columns.
    // ------------------------------------------------------------------------
    class warp_scoreboard;
        slot_t              window [NUM_LEVELS];
        logic [DEPTH_W-1:0] depth_floor_q;
        logic [DEPTH_W-1:0] depth_ceiling_q;
        column_t            columns_due [$];
        int                 errors;
        int                 pixels_taken;
        int                 rows_closed;
        int                 holes_seen;
        int                 clamped_levels;
        int                 range_settings;

        function new();
            foreach (window[k]) window[k] = SLOT_EMPTY;
            depth_floor_q   = FLOOR_RESET;
            depth_ceiling_q = CEILING_RESET;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [DEPTH_W-1:0] data);
            if (idx == REG_DEPTH_FLOOR)
                depth_floor_q = data;
            else if (idx == REG_DEPTH_CEILING)
                depth_ceiling_q = data;
        endfunction

        // first level k whose threshold floor + k * step covers the depth
        function int depth_level(input logic [DEPTH_W-1:0] depth);
            int lo;
            int hi;
            int step_sz;
            lo = int'(depth_floor_q);
            hi = int'(depth_ceiling_q);
            step_sz = (hi >= lo) ? (hi - lo + 1) / NUM_LEVELS : 0;
            for (int k = 1; k <= NUM_LEVELS; k++) begin
                if (int'(depth) <= lo + k * step_sz)
                    return k;
            end
            clamped_levels++;
            return NUM_LEVELS;
        endfunction

        function void take_pixel(input logic [PIX_W-1:0] r, g, b,
                                 input logic [DEPTH_W-1:0] depth,
                                 input logic row_last);
            column_t col;
            int      lvl;
            col.filled  = window[0].valid;
            col.red     = window[0].valid ? window[0].red   : '0;
            col.green   = window[0].valid ? window[0].green : '0;
            col.blue    = window[0].valid ? window[0].blue  : '0;
            col.row_end = row_last;
            columns_due.push_back(col);
            pixels_taken++;
            if (row_last) begin
                // the last pixel would land past the row: drop it, clear the window
                foreach (window[k]) window[k] = SLOT_EMPTY;
                rows_closed++;
                return;
            end
            for (int k = 0; k < NUM_LEVELS - 1; k++)
                window[k] = window[k + 1];
            window[NUM_LEVELS - 1] = SLOT_EMPTY;
            lvl = depth_level(depth);
            // keep the occupant unless the newcomer sits on a strictly higher level
            if (!window[lvl - 1].valid || lvl > int'(window[lvl - 1].level)) begin
                window[lvl - 1].valid = 1'b1;
                window[lvl - 1].level = LVL_W'(lvl);
                window[lvl - 1].red   = r;
                window[lvl - 1].green = g;
                window[lvl - 1].blue  = b;
            end
        endfunction

        function void compare_field(input string field, input int unsigned want,
                                    input int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_column(input column_t got);
            column_t want;
            if (columns_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected column: expected none, actual %h", $time, got);
                return;
            end
            want = columns_due.pop_front();
            if (!want.filled)
                holes_seen++;
            compare_field("out_red",     want.red,     got.red);
            compare_field("out_green",   want.green,   got.green);
            compare_field("out_blue",    want.blue,    got.blue);
            compare_field("filled",      want.filled,  got.filled);
            compare_field("out_row_end", want.row_end, got.row_end);
        endfunction

        function void check_drained();
            if (columns_due.size() != 0) begin
                errors += columns_due.size();
                $display("%0t: missing columns: expected %0d more, actual 0",
                         $time, columns_due.size());
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [PIX_W-1:0]     s_red         = '0;
    logic [PIX_W-1:0]     s_green       = '0;
    logic [PIX_W-1:0]     s_blue        = '0;
    logic [DEPTH_W-1:0]   s_depth_value = '0;
    logic                 s_row_end     = 1'b0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [PIX_W-1:0]     m_out_red;
    logic [PIX_W-1:0]     m_out_green;
    logic [PIX_W-1:0]     m_out_blue;
    logic                 m_filled;
    logic                 m_out_row_end;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [DEPTH_W-1:0]   cfg_data      = '0;

    pace_t          pace = SENDER_SLOW;
    warp_scoreboard sb   = new;
    int             quiet_cycles = 0;

    always #10 aclk = ~aclk;

    depth_quantized_row_warp DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .s_depth_value (s_depth_value),
        .s_row_end     (s_row_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_red     (m_out_red),
        .m_out_green   (m_out_green),
        .m_out_blue    (m_out_blue),
        .m_filled      (m_filled),
        .m_out_row_end (m_out_row_end),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // percentage of cycles in which each side holds back
    function int sender_gap_pct();
        return (pace == SENDER_SLOW) ? 28 : (pace == RECEIVER_SLOW) ? 80 : 0;
    endfunction

    function int receiver_gap_pct();
        return (pace == SENDER_SLOW) ? 80 : (pace == RECEIVER_SLOW) ? 28 : 0;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: check the column taken at this edge, then pick the next ready
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_column({m_out_red, m_out_green, m_out_blue, m_filled, m_out_row_end});
            m_ready <= ($urandom_range(0, 99) >= receiver_gap_pct());
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: abort when no channel has moved an item for too long
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one pixel after random gaps; hold it until taken, then predict.
    // Valid stays high on return so back-to-back pixels keep full rate.
    task automatic send_pixel(input logic [PIX_W-1:0] r, g, b,
                              input logic [DEPTH_W-1:0] depth,
                              input logic row_last);
        while ($urandom_range(0, 99) < sender_gap_pct()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_red         <= r;
        s_green       <= g;
        s_blue        <= b;
        s_depth_value <= depth;
        s_row_end     <= row_last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.take_pixel(r, g, b, depth, row_last);
    endtask

    // Drop valid and wait until every predicted column has come back.
    task automatic drain_columns(input int settle);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.columns_due.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [DEPTH_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Reprogram the depth range on an idle block. A write to an unused index
    // goes first and must change nothing.
    task automatic set_depth_range(input logic [DEPTH_W-1:0] lo, hi);
        drain_columns(6);
        write_register(CFG_IDX_W'($urandom_range(int'(REG_DEPTH_CEILING) + 1, 255)),
                       DEPTH_W'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) begin
            write_register(REG_DEPTH_FLOOR, lo);
            write_register(REG_DEPTH_CEILING, hi);
        end else begin
            write_register(REG_DEPTH_CEILING, hi);
            write_register(REG_DEPTH_FLOOR, lo);
        end
        // let the level thresholds settle before new pixels
        repeat (4) @(posedge aclk);
        sb.range_settings++;
    endtask

    // Mostly uniform depths; the rest sit on or next to a level threshold.
    function automatic logic [DEPTH_W-1:0] pick_depth();
        int lo;
        int hi;
        int step_sz;
        int v;
        if ($urandom_range(0, 99) < 70)
            return DEPTH_W'($urandom_range(0, 255));
        lo = int'(sb.depth_floor_q);
        hi = int'(sb.depth_ceiling_q);
        step_sz = (hi >= lo) ? (hi - lo + 1) / NUM_LEVELS : 0;
        v = lo + int'($urandom_range(0, NUM_LEVELS)) * step_sz + int'($urandom_range(0, 2)) - 1;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return DEPTH_W'(v);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int            sent;
        int            row_left;
        int            hold_at;
        logic [7:0]    floors   [CHUNKS];
        logic [7:0]    ceilings [CHUNKS];

        // range per chunk: full, random, narrow, mid, both top, both zero, random, low
        floors   = '{8'd0,   8'd0, 8'd0, 8'd40, 8'd255, 8'd0, 8'd0, 8'd0};
        ceilings = '{8'd255, 8'd0, 8'd7, 8'd90, 8'd255, 8'd0, 8'd0, 8'd63};
        floors[1]   = 8'($urandom_range(0, 127));
        ceilings[1] = 8'($urandom_range(128, 255));
        floors[6]   = 8'($urandom_range(0, 255));
        ceilings[6] = 8'($urandom_range(0, 255));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Reset range (step 32): both depth extremes, both sides of a threshold,
        // a collision and a row end that drops its own pixel.
        send_pixel(8'hff, 8'h00, 8'hff, 8'd0,   1'b0);
        send_pixel(8'h00, 8'hff, 8'h00, 8'd255, 1'b0);
        send_pixel(8'h12, 8'h34, 8'h56, 8'd32,  1'b0);
        send_pixel(8'h80, 8'h7f, 8'h01, 8'd33,  1'b0);
        send_pixel(8'haa, 8'h55, 8'haa, 8'd96,  1'b0);
        send_pixel(8'h55, 8'haa, 8'h55, 8'd97,  1'b0);
        send_pixel(8'h01, 8'h02, 8'h03, 8'd224, 1'b0);
        send_pixel(8'hfe, 8'hfd, 8'hfc, 8'd64,  1'b0);
        send_pixel(8'hff, 8'hff, 8'hff, 8'd225, 1'b1);
        // one-pixel row: a hole in an empty window
        send_pixel(8'h00, 8'h00, 8'h00, 8'd128, 1'b1);
        // far pixels only: every column of the row is a hole
        send_pixel(8'h3c, 8'hc3, 8'h5a, 8'd255, 1'b0);
        send_pixel(8'ha5, 8'h5a, 8'h3c, 8'd255, 1'b0);
        send_pixel(8'h0f, 8'hf0, 8'h99, 8'd255, 1'b1);

        // depths past the last threshold clamp to the top level
        set_depth_range(8'd0, 8'd20);
        send_pixel(8'h11, 8'h22, 8'h33, 8'd200, 1'b0);
        send_pixel(8'h44, 8'h55, 8'h66, 8'd10,  1'b0);
        send_pixel(8'h77, 8'h88, 8'h99, 8'd16,  1'b0);
        send_pixel(8'hcc, 8'hdd, 8'hee, 8'd17,  1'b1);

        // depths below the floor take level one
        set_depth_range(8'd100, 8'd255);
        send_pixel(8'h21, 8'h43, 8'h65, 8'd5,   1'b0);
        send_pixel(8'h87, 8'ha9, 8'hcb, 8'd99,  1'b0);
        send_pixel(8'hed, 8'h0f, 8'h21, 8'd100, 1'b0);
        send_pixel(8'h9a, 8'hbc, 8'hde, 8'd255, 1'b1);

        // ceiling below floor: zero step, so level one or the top level only
        set_depth_range(8'd200, 8'd50);
        send_pixel(8'h13, 8'h57, 8'h9b, 8'd200, 1'b0);
        send_pixel(8'hdf, 8'h02, 8'h46, 8'd201, 1'b0);
        send_pixel(8'h8a, 8'hce, 8'h35, 8'd0,   1'b0);
        send_pixel(8'h79, 8'hbd, 8'hf1, 8'd255, 1'b1);

        // Random rows in chunks: each chunk gets its own range and one of three flow
        // paces, and holds the sender once mid-stream until all columns are back.
        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            pace = (chunk < 3) ? SENDER_SLOW : (chunk < 6) ? RECEIVER_SLOW : FULL_RATE;
            set_depth_range(floors[chunk], ceilings[chunk]);
            sent     = 0;
            row_left = 0;
            hold_at  = $urandom_range(40, 180);
            while (sent < CHUNK_ITEMS || row_left != 0) begin
                if (row_left == 0) begin
                    case ($urandom_range(0, 19))
                        0, 1:    row_left = 1;
                        2, 3, 4: row_left = $urandom_range(25, 64);
                        default: row_left = $urandom_range(2, 24);
                    endcase
                end
                send_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                           PIX_W'($urandom_range(0, 255)), pick_depth(), row_left == 1);
                row_left--;
                sent++;
                if (sent == hold_at)
                    drain_columns(1);
            end
        end

        // wait out the last columns, then watch a little longer for strays
        drain_columns(16);
        sb.check_drained();

        $display("Run covered %0d pixels in %0d rows over %0d depth ranges.",
                 sb.pixels_taken, sb.rows_closed, sb.range_settings);
        $display("Saw %0d hole columns and %0d clamped depth levels; %0d errors.",
                 sb.holes_seen, sb.clamped_levels, sb.errors);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
